FILE: design/ilss_pkg.sv
// ----------------------------------------------------------------------------
// ilss_pkg: shared types and constants of the indexed list shift store
// Capacity, word size, action and status codes, and the command that the
// list controller broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package ilss_pkg;

	// list geometry
	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 32;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int IDX_W     = $clog2(CAPACITY);

	// fixed field widths
	localparam int ACT_W = 3;
	localparam int POS_W = 5;
	localparam int ST_W  = 2;

	// action codes
	localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DROP   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd5;
	localparam logic [ACT_W-1:0] ACT_RESIZE = 3'd6;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [IDX_W-1:0]     idx_t;

	// command broadcast to every cell in the row
	typedef struct packed {
		logic             commit;
		logic [ACT_W-1:0] action;
		cnt_t             pos;
		cnt_t             count;
		cnt_t             target;
		word_t            value;
	} cell_cmd_t;

endpackage

FILE: design/ilss_cell.sv
// ----------------------------------------------------------------------------
// ilss_cell: one storage slot of the list
// Holds one word and, on a committed command, loads the new word, takes
// its lower or upper neighbor's word, or clears, depending on its index.
// ----------------------------------------------------------------------------
module ilss_cell (
	input  logic               clk,
	input  ilss_pkg::idx_t     idx,
	input  ilss_pkg::cell_cmd_t cmd,
	input  ilss_pkg::word_t    lower_word,
	input  ilss_pkg::word_t    upper_word,
	output ilss_pkg::word_t    word
);
	import ilss_pkg::*;

	word_t word_q;
	word_t word_nxt;
	cnt_t  me;
	cnt_t  me_plus;

	assign me      = CNT_W'(idx);
	assign me_plus = me + 1'b1;

	// next word for this slot
	always_comb begin
		word_nxt = word_q;
		if (cmd.commit) begin
			unique case (cmd.action)
				ACT_APPEND: begin
					if (me == cmd.count) word_nxt = cmd.value;
				end
				ACT_INSERT: begin
					if (me == cmd.pos) word_nxt = cmd.value;
					else if (me > cmd.pos && me <= cmd.count) word_nxt = lower_word;
				end
				ACT_ERASE: begin
					if (me >= cmd.pos && me_plus < cmd.count) word_nxt = upper_word;
				end
				ACT_WRITE: begin
					if (me == cmd.pos) word_nxt = cmd.value;
				end
				ACT_RESIZE: begin
					if (me >= cmd.count && me < cmd.target) word_nxt = '0;
				end
				default: word_nxt = word_q;
			endcase
		end
	end

	// slot register
	always_ff @(posedge clk) begin
		word_q <= word_nxt;
	end

	assign word = word_q;

endmodule

FILE: design/ilss_ctrl.sv
// ----------------------------------------------------------------------------
// ilss_ctrl: list controller
// Holds the element count, checks bounds and capacity for each word and
// builds the command that the cell row executes in the same cycle.
// ----------------------------------------------------------------------------
module ilss_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [ilss_pkg::ACT_W-1:0] action,
	input  logic [ilss_pkg::POS_W-1:0] position,
	input  ilss_pkg::word_t            value,
	input  logic [ilss_pkg::POS_W-1:0] new_length,
	output ilss_pkg::cell_cmd_t        cmd,
	output ilss_pkg::cnt_t             count_next,
	output logic [ilss_pkg::ST_W-1:0]  status_next,
	output logic                       read_ok
);
	import ilss_pkg::*;

	localparam cnt_t CAP_C = CNT_W'(CAPACITY);

	cnt_t             count_q;
	cnt_t             pos_c;
	cnt_t             target_c;
	logic             pos_in;
	logic             ok;
	logic [ST_W-1:0]  st;
	cnt_t             cnt_nxt;

	assign pos_c    = CNT_W'(position);
	assign target_c = CNT_W'(new_length);
	assign pos_in   = pos_c < count_q;

	// bounds and capacity checks, next count
	always_comb begin
		st      = ST_OK;
		cnt_nxt = count_q;
		unique case (action) inside
			ACT_APPEND: begin
				if (count_q >= CAP_C) st = ST_FULL;
				else cnt_nxt = count_q + 1'b1;
			end
			ACT_DROP: begin
				if (count_q == '0) st = ST_EMPTY;
				else cnt_nxt = count_q - 1'b1;
			end
			ACT_INSERT: begin
				if (pos_c > count_q) st = ST_RANGE;
				else if (count_q >= CAP_C) st = ST_FULL;
				else cnt_nxt = count_q + 1'b1;
			end
			ACT_ERASE: begin
				if (!pos_in) st = ST_RANGE;
				else cnt_nxt = count_q - 1'b1;
			end
			ACT_READ, ACT_WRITE: begin
				if (!pos_in) st = ST_RANGE;
			end
			ACT_RESIZE: begin
				if (target_c > CAP_C) st = ST_FULL;
				else cnt_nxt = target_c;
			end
			default: st = ST_OK;
		endcase
	end

	assign ok = (st == ST_OK);

	// command to the cell row
	always_comb begin
		cmd.commit = fire && ok;
		cmd.action = action;
		cmd.pos    = pos_c;
		cmd.count  = count_q;
		cmd.target = target_c;
		cmd.value  = value;
	end

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= cnt_nxt;
		end
	end

	assign count_next  = cnt_nxt;
	assign status_next = st;
	assign read_ok     = (action == ACT_READ) && ok;

endmodule

FILE: design/indexed_list_shift_store_core.sv
// ----------------------------------------------------------------------------
// indexed_list_shift_store_core: fixed-capacity ordered list of signed words
// A row of storage cells that shift in parallel, a controller that keeps
// the element count, and one output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word: action, position,
//   value and new_length. Output channel (out_valid/out_ready) returns one
//   word per input word: read_value, length, empty_res and status.
//   Every action, insert and erase included, executes in the cycle it is
//   accepted: all cells of the row update together, each from its own
//   slot, its neighbor or the new value.
//   out_valid rises in the cycle after input acceptance. Throughput is
//   one word per cycle while out_ready is high; the single output register
//   is refilled in the cycle it is emptied.
//   While the receiver stalls with a result pending, in_ready stays low
//   and the list holds still.
//   Reset clears the element count and the output valid flag; slot contents
//   are undefined until written, and no slot below length is ever unwritten.
// ----------------------------------------------------------------------------
module indexed_list_shift_store_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ilss_pkg::ACT_W-1:0] action,
	input  logic [ilss_pkg::POS_W-1:0] position,
	input  logic signed [31:0]         value,
	input  logic [ilss_pkg::POS_W-1:0] new_length,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [31:0]         read_value,
	output logic [4:0]                 length,
	output logic                       empty_res,
	output logic [ilss_pkg::ST_W-1:0]  status
);
	import ilss_pkg::*;

	logic            fire;
	cell_cmd_t       cmd;
	cnt_t            count_next;
	logic [ST_W-1:0] status_next;
	logic            read_ok;
	word_t           cell_word [CAPACITY];
	word_t           rd_word;

	logic            out_valid_q;
	word_t           read_value_q;
	cnt_t            length_q;
	logic            empty_q;
	logic [ST_W-1:0] status_q;

	// input handshake
	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	// controller
	ilss_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.action      (action),
		.position    (position),
		.value       (WORD_BITS'(value)),
		.new_length  (new_length),
		.cmd         (cmd),
		.count_next  (count_next),
		.status_next (status_next),
		.read_ok     (read_ok)
	);

	// row of cells, each wired to its neighbors
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		word_t lower_w;
		word_t upper_w;
		if (g == 0) begin : g_first
			assign lower_w = '0;
		end else begin : g_mid_lo
			assign lower_w = cell_word[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign upper_w = '0;
		end else begin : g_mid_hi
			assign upper_w = cell_word[g+1];
		end
		ilss_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(g)),
			.cmd        (cmd),
			.lower_word (lower_w),
			.upper_word (upper_w),
			.word       (cell_word[g])
		);
	end

	// read select
	assign rd_word = read_ok ? cell_word[position[IDX_W-1:0]] : '0;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (fire) begin
			read_value_q <= rd_word;
			length_q     <= count_next;
			empty_q      <= (count_next == '0);
			status_q     <= status_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = 32'(read_value_q);
	assign length     = 5'(length_q);
	assign empty_res  = empty_q;
	assign status     = status_q;

	// checks
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (length_q <= CNT_W'(CAPACITY)))
		else $error("length above capacity");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (empty_q == (length_q == '0)))
		else $error("empty flag disagrees with length");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (read_value_q == '0))
		else $error("failed word returned nonzero read value");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("accepted word produced no result");

endmodule

FILE: sim/indexed_list_shift_store_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_shift_store_core_tb: self-checking bench for the list core
// Drives action words through the valid/ready input channel and tracks the
// list contents in a local model to predict every result word. Results are
// compared field by field in arrival order. Both channels idle at random,
// and the sender drains the pipe now and then.
// ----------------------------------------------------------------------------
module indexed_list_shift_store_core_tb;
	import ilss_pkg::*;

	// action code the core has no use for
	localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
	localparam int POS_MAX = (1 << POS_W) - 1;
	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 4;

	typedef struct packed {
		word_t           read_value;
		cnt_t            length;
		logic            empty_res;
		logic [ST_W-1:0] status;
	} list_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ACT_W-1:0]    action = '0;
	logic [POS_W-1:0]    position = '0;
	logic signed [31:0]  value = '0;
	logic [POS_W-1:0]    new_length = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic signed [31:0]  read_value;
	logic [4:0]          length;
	logic                empty_res;
	logic [ST_W-1:0]     status;

	// local copy of the list
	word_t        list_words [CAPACITY];
	int           list_len = 0;
	list_result_t expected_q [$];
	list_result_t front_result;

	bit idle_enable = 1'b1;
	int rx_wait = 0;
	int idle_cycles = 0;
	int fail_count = 0;

	indexed_list_shift_store_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.position   (position),
		.value      (value),
		.new_length (new_length),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.length     (length),
		.empty_res  (empty_res),
		.status     (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		return idle_enable ? $urandom_range(0, 3) : 0;
	endfunction

	// apply one action word to the local list and return the result word
	function automatic list_result_t apply_list_action(logic [ACT_W-1:0] act,
			logic [POS_W-1:0] pos, word_t val, logic [POS_W-1:0] tgt);
		list_result_t res;
		int p;
		int t;
		int i;
		p = pos;
		t = tgt;
		res.read_value = '0;
		res.status = ST_OK;
		case (act)
			ACT_APPEND: begin
				if (list_len >= CAPACITY) res.status = ST_FULL;
				else begin
					list_words[list_len] = val;
					list_len++;
				end
			end
			ACT_DROP: begin
				if (list_len == 0) res.status = ST_EMPTY;
				else list_len--;
			end
			ACT_INSERT: begin
				if (p > list_len) res.status = ST_RANGE;
				else if (list_len >= CAPACITY) res.status = ST_FULL;
				else begin
					for (i = list_len; i > p; i--) list_words[i] = list_words[i-1];
					list_words[p] = val;
					list_len++;
				end
			end
			ACT_ERASE: begin
				if (p >= list_len) res.status = ST_RANGE;
				else begin
					for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			ACT_READ: begin
				if (p >= list_len) res.status = ST_RANGE;
				else res.read_value = list_words[p];
			end
			ACT_WRITE: begin
				if (p >= list_len) res.status = ST_RANGE;
				else list_words[p] = val;
			end
			ACT_RESIZE: begin
				if (t > CAPACITY) res.status = ST_FULL;
				else begin
					// growing fills the new slots with zero
					for (i = list_len; i < t; i++) list_words[i] = '0;
					list_len = t;
				end
			end
			default: ;
		endcase
		res.length = cnt_t'(list_len);
		res.empty_res = (list_len == 0);
		return res;
	endfunction

	// present one word, wait for the handshake, then log its prediction
	task automatic send_word(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
			input word_t val, input logic [POS_W-1:0] tgt);
		int gap;
		list_result_t pred;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		position <= pos;
		value <= val;
		new_length <= tgt;
		do @(posedge clk); while (!in_ready);
		pred = apply_list_action(act, pos, val, tgt);
		expected_q = {expected_q, pred};
	endtask

	// drop valid and hold off until every pending result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [POS_W-1:0] pick_position(logic [ACT_W-1:0] act);
		int r;
		int top;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			top = (act == ACT_INSERT) ? list_len : list_len - 1;
			if (top < 0) top = 0;
			return $urandom_range(0, top);
		end
		if (r < 9) return $urandom_range(0, CAPACITY);
		return $urandom_range(CAPACITY + 1, POS_MAX);
	endfunction

	function automatic word_t pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_length();
		if ($urandom_range(0, 11) == 0) return $urandom_range(CAPACITY + 1, POS_MAX);
		return $urandom_range(0, CAPACITY);
	endfunction

	// grow_pct steers structural actions toward filling or draining the list
	task automatic send_random_word(input int grow_pct);
		logic [ACT_W-1:0] act;
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) act = ACT_RESIZE;
		else if (r < 4) act = ACT_UNUSED;
		else if (r < 36) act = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
		else if ($urandom_range(0, 99) < grow_pct)
			act = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
		else act = $urandom_range(0, 1) ? ACT_DROP : ACT_ERASE;
		send_word(act, pick_position(act), pick_value(), pick_length());
	endtask

	// boundaries and every error code
	task automatic test_edge_cases();
		send_word(ACT_DROP, 0, '0, 0);
		send_word(ACT_READ, 0, '0, 0);
		send_word(ACT_ERASE, 0, '0, 0);
		send_word(ACT_WRITE, 0, 32'h1234_5678, 0);
		send_word(ACT_INSERT, 1, 32'h1111_1111, 0);
		send_word(ACT_INSERT, 0, 32'h8000_0000, 0);
		send_word(ACT_APPEND, 0, 32'h7FFF_FFFF, 0);
		send_word(ACT_APPEND, 0, 32'hFFFF_FFFF, 0);
		// insert at the end acts as append
		send_word(ACT_INSERT, 3, '0, 0);
		send_word(ACT_INSERT, 1, 32'h0000_0001, 0);
		send_word(ACT_READ, 0, '0, 0);
		send_word(ACT_READ, 4, '0, 0);
		send_word(ACT_READ, 5, '0, 0);
		send_word(ACT_WRITE, 2, 32'h5555_5555, 0);
		send_word(ACT_READ, 2, '0, 0);
		send_word(ACT_ERASE, 0, '0, 0);
		send_word(ACT_ERASE, 3, '0, 0);
		send_word(ACT_RESIZE, 0, '0, CAPACITY);
		send_word(ACT_READ, CAPACITY - 1, '0, 0);
		send_word(ACT_APPEND, 0, 32'hAAAA_AAAA, 0);
		send_word(ACT_INSERT, CAPACITY, 32'hAAAA_AAAA, 0);
		send_word(ACT_INSERT, CAPACITY + 1, 32'hAAAA_AAAA, 0);
		send_word(ACT_READ, POS_MAX, '0, 0);
		send_word(ACT_RESIZE, 0, '0, POS_MAX);
		send_word(ACT_RESIZE, 0, '0, CAPACITY + 1);
		send_word(ACT_UNUSED, POS_MAX, '1, POS_MAX);
		send_word(ACT_RESIZE, 0, '0, 0);
		send_word(ACT_READ, 0, '0, 0);
	endtask

	// random traffic in fill, balanced and drain phases
	task automatic test_mixed_traffic(input int n_words);
		int k;
		for (k = 0; k < n_words; k++) begin
			case ((k / 40) % 3)
				0: send_random_word(85);
				1: send_random_word(50);
				default: send_random_word(15);
			endcase
		end
	endtask

	// no idling on either side
	task automatic test_back_to_back(input int n_words);
		int k;
		idle_enable = 1'b0;
		for (k = 0; k < n_words; k++) send_random_word((k / 30) % 2 ? 20 : 80);
		idle_enable = 1'b1;
	endtask

	// short bursts with the pipe emptied in between
	task automatic test_drain_between_bursts(input int n_bursts);
		int b;
		int k;
		for (b = 0; b < n_bursts; b++) begin
			for (k = 0; k < 30; k++) send_random_word(b % 2 ? 30 : 70);
			drain_results();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// result checking, receiver stalls and watchdog
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				fail_count++;
				$display("%0t: result word with nothing expected, expected none, got length %0d",
					$time, length);
			end else begin
				front_result = expected_q.pop_front();
				check_field("read_value", front_result.read_value, read_value);
				check_field("length", front_result.length, length);
				check_field("empty_res", front_result.empty_res, empty_res);
				check_field("status", front_result.status, status);
			end
			rx_wait = draw_gap();
		end else if (rx_wait > 0) begin
			rx_wait--;
		end
		out_ready <= arst_n && (rx_wait == 0);

		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_cases();
		test_mixed_traffic(900);
		test_back_to_back(300);
		test_drain_between_bursts(10);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
